// ===== sv/vfc_pkg.sv =====
package vfc_pkg;

    // Command codes.
    localparam logic [1:0] CMD_WRITE_VOXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE_PLANE = 2'd1;
    localparam logic [1:0] CMD_MESH        = 2'd2;
    localparam logic [1:0] CMD_RESTART     = 2'd3;

    // Face codes, also the order in which faces are emitted.
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;
    localparam logic [2:0] FACE_NONE  = 3'd6;

    // Neighbour plane codes.
    localparam logic [1:0] PLANE_POS_X = 2'd0;
    localparam logic [1:0] PLANE_NEG_X = 2'd1;
    localparam logic [1:0] PLANE_POS_Z = 2'd2;
    localparam logic [1:0] PLANE_NEG_Z = 2'd3;

    // Corner offsets packed as {dx, dy, dz}, per face and corner.
    localparam logic [2:0] CORNER_OFF [6][4] = '{
        '{3'd4, 3'd6, 3'd7, 3'd5},
        '{3'd0, 3'd1, 3'd3, 3'd2},
        '{3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd4, 3'd5, 3'd1},
        '{3'd1, 3'd5, 3'd7, 3'd3},
        '{3'd0, 3'd2, 3'd6, 3'd4}
    };

    // Texture coordinates, bit c belongs to corner c.
    localparam logic [3:0] CORNER_U = 4'b0110;
    localparam logic [3:0] CORNER_V = 4'b1100;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] pos_x;
        logic [5:0] pos_y;
        logic [3:0] pos_z;
        logic       solid;
        logic [1:0] neighbour;
    } vfc_in_t;

    typedef struct packed {
        logic        vertex_valid;
        logic [4:0]  vert_x;
        logic [6:0]  vert_y;
        logic [4:0]  vert_z;
        logic [2:0]  face;
        logic        tex_u;
        logic        tex_v;
        logic [18:0] vertex_index;
        logic        last;
        logic        scan_done;
    } vfc_out_t;

    // Where the data of a pending neighbour read comes from.
    typedef struct packed {
        logic forced;
        logic plane;
    } vfc_src_t;

endpackage

// ===== sv/voxel_face_cull_mesher.sv =====
// Voxel culled-face mesher.
// One command channel: a transaction is taken at a rising edge where start is
// high and busy is low. Commands write a chunk voxel, write a cell of one of the
// four neighbour boundary planes, mesh the next voxel of the scan, or restart
// the scan. Writes and restart give no result and leave busy low.
// A mesh command reads the voxel and its six neighbours through the single read
// port of the chunk or plane memory, seven reads one per cycle. It then emits
// one result per cycle: four vertices for each exposed face, or one empty
// result when nothing is exposed. A command gives 1 to 24 results and keeps
// busy high until the final one is registered. Results are strobed for one
// cycle by result_strobe and cannot be held off; the final one of a command
// carries last.
// Reset clears the scan position and vertex counter; the voxel and plane
// memories are not cleared and must be written before they are meshed.
module voxel_face_cull_mesher
    import vfc_pkg::*;
#(
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  vfc_in_t  request,
    output logic     busy,
    output logic     result_strobe,
    output vfc_out_t result
);

    localparam int XW          = $clog2(CHUNK_WIDTH);
    localparam int YW          = $clog2(CHUNK_HEIGHT);
    localparam int MW          = (XW > YW) ? XW : YW;
    localparam int CA          = 2 * XW + YW;
    localparam int PA          = 2 + YW + XW;
    localparam int CHUNK_DEPTH = 1 << CA;
    localparam int PLANE_DEPTH = 1 << PA;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [XW-1:0]   scan_x_reg, scan_x_next;
    logic [YW-1:0]   scan_y_reg, scan_y_next;
    logic [XW-1:0]   scan_z_reg, scan_z_next;
    logic [XW-1:0]   cur_x_reg, cur_x_next;
    logic [YW-1:0]   cur_y_reg, cur_y_next;
    logic [XW-1:0]   cur_z_reg, cur_z_next;
    logic            done_reg, done_next;
    logic [18:0]     vcount_reg, vcount_next;
    logic [2:0]      rd_k_reg, rd_k_next;
    vfc_src_t        src_reg, src_next;
    logic [6:0]      occ_reg, occ_next;
    logic [2:0]      face_reg, face_next;
    logic [1:0]      corner_reg, corner_next;
    vfc_out_t        result_reg, result_next;
    logic            strobe_reg, strobe_next;

    logic            accept;
    logic            chunk_we, plane_we;
    logic [CA-1:0]   chunk_waddr, chunk_raddr;
    logic [PA-1:0]   plane_waddr, plane_raddr;
    logic [3:0]      wr_along;
    logic            chunk_rdata, plane_rdata;

    logic [2:0]      rd_face;
    logic [MW-1:0]   operand, operand_lim, stepped;
    logic            step_up, boundary, y_face;
    logic [XW-1:0]   nb_x, nb_z, rd_along;
    logic [YW-1:0]   nb_y;
    logic [1:0]      rd_plane;
    logic            captured;
    logic            scan_last;

    logic [5:0]      exposed;
    logic [2:0]      eff_face, next_face;
    logic            more_faces;
    logic [2:0]      off;

    function automatic logic [2:0] first_set(input logic [5:0] vec, input logic [2:0] from);
        logic [2:0] idx;
        idx = FACE_NONE;
        for (int i = 5; i >= 0; i--)
        begin
            if (vec[i] && (3'(i) >= from))
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // Store writes happen in the cycle the command is taken.
    assign chunk_we = accept && (request.command == CMD_WRITE_VOXEL)
                      && (int'(request.pos_x) < CHUNK_WIDTH)
                      && (int'(request.pos_y) < CHUNK_HEIGHT)
                      && (int'(request.pos_z) < CHUNK_WIDTH);
    assign wr_along = (request.neighbour == PLANE_POS_X || request.neighbour == PLANE_NEG_X)
                      ? request.pos_z : request.pos_x;
    assign plane_we = accept && (request.command == CMD_WRITE_PLANE)
                      && (int'(request.pos_y) < CHUNK_HEIGHT)
                      && (int'(wr_along) < CHUNK_WIDTH);
    assign chunk_waddr = {XW'(request.pos_x), YW'(request.pos_y), XW'(request.pos_z)};
    assign plane_waddr = {request.neighbour, YW'(request.pos_y), XW'(wr_along)};

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (CHUNK_DEPTH)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (chunk_we),
        .waddr (chunk_waddr),
        .wdata (request.solid),
        .raddr (chunk_raddr),
        .rdata (chunk_rdata)
    );

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (PLANE_DEPTH)
    ) u_plane_ram (
        .clk   (clk),
        .we    (plane_we),
        .waddr (plane_waddr),
        .wdata (request.solid),
        .raddr (plane_raddr),
        .rdata (plane_rdata)
    );

    // Neighbour address unit: one increment or decrement on the coordinate
    // that the face being read moves along.
    always_comb
    begin
        rd_face = rd_k_reg - 3'd1;
        y_face  = (rd_face == FACE_POS_Y) || (rd_face == FACE_NEG_Y);
        step_up = !rd_face[0];
        if (rd_face == FACE_POS_X || rd_face == FACE_NEG_X)
        begin
            operand = MW'(cur_x_reg);
        end
        else if (y_face)
        begin
            operand = MW'(cur_y_reg);
        end
        else
        begin
            operand = MW'(cur_z_reg);
        end
        operand_lim = y_face ? MW'(CHUNK_HEIGHT - 1) : MW'(CHUNK_WIDTH - 1);
        stepped     = step_up ? (operand + MW'(1)) : (operand - MW'(1));
        boundary    = step_up ? (operand == operand_lim) : (operand == '0);

        nb_x = cur_x_reg;
        nb_y = cur_y_reg;
        nb_z = cur_z_reg;
        if (rd_face == FACE_POS_X || rd_face == FACE_NEG_X)
        begin
            nb_x = XW'(stepped);
        end
        else if (y_face)
        begin
            nb_y = YW'(stepped);
        end
        else
        begin
            nb_z = XW'(stepped);
        end

        unique case (rd_face)
            FACE_POS_X: rd_plane = PLANE_POS_X;
            FACE_NEG_X: rd_plane = PLANE_NEG_X;
            FACE_POS_Z: rd_plane = PLANE_POS_Z;
            default:    rd_plane = PLANE_NEG_Z;
        endcase
        rd_along = (rd_face == FACE_POS_X || rd_face == FACE_NEG_X) ? cur_z_reg : cur_x_reg;

        if (rd_k_reg == 3'd0)
        begin
            chunk_raddr = {cur_x_reg, cur_y_reg, cur_z_reg};
        end
        else
        begin
            chunk_raddr = {nb_x, nb_y, nb_z};
        end
        plane_raddr = {rd_plane, cur_y_reg, rd_along};
    end

    assign captured  = src_reg.forced ? 1'b0 : (src_reg.plane ? plane_rdata : chunk_rdata);
    assign scan_last = (scan_x_reg == XW'(CHUNK_WIDTH - 1))
                       && (scan_y_reg == YW'(CHUNK_HEIGHT - 1))
                       && (scan_z_reg == XW'(CHUNK_WIDTH - 1));

    always_comb
    begin
        for (int f = 0; f < 6; f++)
        begin
            exposed[f] = occ_reg[0] && !occ_reg[f + 1];
        end
        eff_face   = first_set(exposed, face_reg);
        next_face  = first_set(exposed, eff_face + 3'd1);
        more_faces = (next_face != FACE_NONE);
        off        = CORNER_OFF[(eff_face > FACE_NEG_Z) ? FACE_POS_X : eff_face][corner_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        scan_z_next = scan_z_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        cur_z_next  = cur_z_reg;
        done_next   = done_reg;
        vcount_next = vcount_reg;
        rd_k_next   = rd_k_reg;
        src_next    = src_reg;
        occ_next    = occ_reg;
        face_next   = face_reg;
        corner_next = corner_reg;
        result_next = result_reg;
        strobe_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.command == CMD_RESTART)
                begin
                    scan_x_next = '0;
                    scan_y_next = '0;
                    scan_z_next = '0;
                    vcount_next = '0;
                end
                else if (accept && request.command == CMD_MESH)
                begin
                    cur_x_next = scan_x_reg;
                    cur_y_next = scan_y_reg;
                    cur_z_next = scan_z_reg;
                    done_next  = scan_last;
                    rd_k_next  = 3'd0;
                    state_next = ST_READ;
                    if (scan_z_reg != XW'(CHUNK_WIDTH - 1))
                    begin
                        scan_z_next = scan_z_reg + XW'(1);
                    end
                    else
                    begin
                        scan_z_next = '0;
                        if (scan_y_reg != YW'(CHUNK_HEIGHT - 1))
                        begin
                            scan_y_next = scan_y_reg + YW'(1);
                        end
                        else
                        begin
                            scan_y_next = '0;
                            scan_x_next = (scan_x_reg == XW'(CHUNK_WIDTH - 1))
                                          ? '0 : scan_x_reg + XW'(1);
                        end
                    end
                end
            end

            ST_READ:
            begin
                // Read k is issued now; the data of read k-1 arrives now.
                src_next.forced = (rd_k_reg != 3'd0) && boundary && y_face;
                src_next.plane  = (rd_k_reg != 3'd0) && boundary && !y_face;
                if (rd_k_reg != 3'd0)
                begin
                    occ_next[rd_k_reg - 3'd1] = captured;
                end
                rd_k_next = rd_k_reg + 3'd1;
                if (rd_k_reg == 3'd7)
                begin
                    face_next   = FACE_POS_X;
                    corner_next = 2'd0;
                    state_next  = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.scan_done = done_reg;
                if (exposed == '0)
                begin
                    result_next.vertex_valid = 1'b0;
                    result_next.vert_x       = '0;
                    result_next.vert_y       = '0;
                    result_next.vert_z       = '0;
                    result_next.face         = '0;
                    result_next.tex_u        = 1'b0;
                    result_next.tex_v        = 1'b0;
                    result_next.vertex_index = '0;
                    result_next.last         = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    result_next.vertex_valid = 1'b1;
                    result_next.vert_x       = 5'(cur_x_reg) + 5'(off[2]);
                    result_next.vert_y       = 7'(cur_y_reg) + 7'(off[1]);
                    result_next.vert_z       = 5'(cur_z_reg) + 5'(off[0]);
                    result_next.face         = eff_face;
                    result_next.tex_u        = CORNER_U[corner_reg];
                    result_next.tex_v        = CORNER_V[corner_reg];
                    result_next.vertex_index = vcount_reg;
                    result_next.last         = (corner_reg == 2'd3) && !more_faces;
                    vcount_next              = vcount_reg + 19'd1;
                    if (corner_reg == 2'd3)
                    begin
                        corner_next = 2'd0;
                        face_next   = eff_face + 3'd1;
                        if (!more_faces)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        face_next   = eff_face;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            scan_x_reg <= '0;
            scan_y_reg <= '0;
            scan_z_reg <= '0;
            vcount_reg <= '0;
            rd_k_reg   <= '0;
            face_reg   <= '0;
            corner_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_x_reg <= scan_x_next;
            scan_y_reg <= scan_y_next;
            scan_z_reg <= scan_z_next;
            vcount_reg <= vcount_next;
            rd_k_reg   <= rd_k_next;
            face_reg   <= face_next;
            corner_reg <= corner_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        cur_z_reg  <= cur_z_next;
        done_reg   <= done_next;
        src_reg    <= src_next;
        occ_reg    <= occ_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("mesher state is not one-hot");

    a_mesh_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command == CMD_MESH) |=> busy)
        else $error("mesh transaction did not start the sequencer");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result strobed right after a last result");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.vertex_valid) |-> result.last)
        else $error("empty result without last");
`endif

endmodule

// ===== sv/vfc_ram.sv =====
module vfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
